/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, command codes and the schedule and round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* rtl/sha256_wram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 word memory
// 64 x 32 message schedule store, one write and one registered read.
// ----------------------------------------------------------------------------
module sha256_wram (
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [5:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [64];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sha256_message_digest_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest unit
// Byte-stream SHA-256 hasher with a memory-held message schedule.
// ----------------------------------------------------------------------------
// Usage:
//  s_tdata carries the message byte and s_tuser the command of each word.
//  Absorb (cmd 0) takes one word per cycle; the 64th byte of a block starts
//  a compression and holds s_tready low until it ends.
//  Finish (cmd 1) pads from the fill point up to byte 63,
//  appends the bit length, compresses (twice, with a second full pad
//  pass, when 56 or more bytes are pending) and sends eight digest words
//  on m_*, word_index 0 first, tlast on word 7.
//  A compression runs the schedule steps, then the round steps, then the
//  hash update, one step at a time through the single write port of the schedule
//  memory and the single round unit.
//  Block words W[0..15] are written to memory as bytes are packed and are
//  mirrored in a 16-word window; W[16..63] are formed from that window.
//  Reset clears the fill count, bit length and output, and loads the hash words with H_INIT.
//  A stalled receiver holds the current digest word; no input is taken
//  until all eight words have gone.
// ----------------------------------------------------------------------------
module sha256_message_digest_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_SCHED, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t      state;
  logic [31:0] hw [8];
  logic [31:0] wv [8];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [63:0] total;
  logic [31:0] acc;         // partial word being packed
  logic [6:0]  t;           // step counter
  logic        fin;         // finishing message
  logic        two_blk;     // second padded block still due
  logic        fin_pad_done; // 0x80 marker already placed
  logic [31:0] win [16];    // last 16 schedule words
  logic [2:0]  oidx;

  // memory port
  logic        we;
  logic [5:0]  waddr;
  logic [31:0] wdata;
  logic [31:0] rd_a;
  logic [5:0]  ra_a;

  sha256_wram u_wram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(ra_a), .rdata(rd_a));

  logic        acc_in;
  logic [7:0]  in_byte;
  logic [31:0] word_next;
  assign s_tready  = (state == S_IDLE);
  assign acc_in    = s_tvalid && s_tready;
  assign in_byte   = s_tdata;
  assign word_next = {acc[23:0], in_byte};

  // pad byte generator for the padding phase (t indexes byte 0..63)
  logic [7:0] pad_byte;
  always_comb begin
    pad_byte = 8'h00;
    if (t[5:0] >= 6'd56 && !two_blk) begin
      // length, big-endian, in bytes 56..63 of the final block
      pad_byte = total[6'd63 - {t[2:0], 3'b000} -: 8];
    end else if (t[5:0] == fill && !fin_pad_done) begin
      pad_byte = 8'h80;
    end
  end

  // schedule step
  logic [31:0] w_new;
  assign w_new = sha256_pkg::sig1(win[14]) + win[9] + sha256_pkg::sig0(win[1]) + win[0];

  // round step; W[t] comes from memory read issued last cycle
  logic [31:0] t1, t2;
  assign t1 = wv[7] + sha256_pkg::bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + sha256_pkg::K_TAB[t[5:0]] + rd_a;
  assign t2 = sha256_pkg::bsig0(wv[0])
            + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  always_comb begin
    we    = 1'b0;
    waddr = 6'd0;
    wdata = word_next;
    ra_a  = 6'd0;           // during S_SCHED: W[0] ready for round 0
    case (state)
      S_IDLE: begin
        we    = acc_in && (s_tuser == sha256_pkg::CMD_ABSORB) && (fill[1:0] == 2'd3);
        waddr = {2'b00, fill[5:2]};
      end
      S_PAD: begin
        we    = (t[1:0] == 2'd3);
        waddr = {2'b00, t[5:2]};
        wdata = {acc[23:0], pad_byte};
      end
      S_SCHED: begin
        we    = 1'b1;
        waddr = t[5:0] + 6'd16;
        wdata = w_new;
      end
      S_ROUND: begin
        ra_a = t[5:0] + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= 6'd0;
      bit_len      <= 64'd0;
      acc          <= 32'd0;
      fin          <= 1'b0;
      two_blk      <= 1'b0;
      fin_pad_done <= 1'b0;
      m_tvalid     <= 1'b0;
      oidx         <= 3'd0;
      t            <= 7'd0;
      for (int i = 0; i < 8; i++) hw[i] <= sha256_pkg::H_INIT[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            if (s_tuser == sha256_pkg::CMD_ABSORB) begin
              acc  <= word_next;
              fill <= fill + 6'd1;
              // window mirrors block words as they are written
              if (fill[1:0] == 2'd3) win[fill[5:2]] <= word_next;
              if (fill == 6'd63) begin
                bit_len <= bit_len + 64'd512;
                fin     <= 1'b0;
                t       <= 7'd0;
                state   <= S_SCHED;
              end
            end else begin
              total        <= bit_len + {55'd0, fill, 3'b000};
              fin          <= 1'b1;
              two_blk      <= (fill >= 6'd56);
              fin_pad_done <= 1'b0;
              // bytes below fill are already in acc / memory
              t            <= {1'b0, fill};
              state        <= S_PAD;
            end
          end
        end
        S_PAD: begin
          acc <= {acc[23:0], pad_byte};
          if (t[1:0] == 2'd3) win[t[5:2]] <= {acc[23:0], pad_byte};
          if (t[5:0] == fill) fin_pad_done <= 1'b1;
          if (t[5:0] == 6'd63) begin
            t     <= 7'd0;
            state <= S_SCHED;
          end else begin
            t <= t + 7'd1;
          end
        end
        S_SCHED: begin
          // W[t+16] from the window, which then slides by one
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_new;
          if (t == 7'd47) begin
            t <= 7'd0;
            for (int i = 0; i < 8; i++) wv[i] <= hw[i];
            state <= S_ROUND;
          end else begin
            t <= t + 7'd1;
          end
        end
        S_ROUND: begin
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          if (t == 7'd63) state <= S_ADD;
          t <= t + 7'd1;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + wv[i];
          if (!fin) begin
            state <= S_IDLE;
          end else if (two_blk) begin
            two_blk <= 1'b0;
            t       <= 7'd0;
            state   <= S_PAD;
          end else begin
            oidx     <= 3'd0;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (oidx == 3'd7) begin
              m_tvalid <= 1'b0;
              fill     <= 6'd0;
              bit_len  <= 64'd0;
              fin      <= 1'b0;
              for (int i = 0; i < 8; i++) hw[i] <= sha256_pkg::H_INIT[i];
              state    <= S_IDLE;
            end
            oidx <= oidx + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = hw[oidx];
  assign m_tuser = oidx;
  assign m_tlast = (oidx == 3'd7);

`ifndef ASSERT_OFF
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("valid outside output");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while sending");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> state == S_IDLE) else $error("bad end");
`endif

endmodule

/* tb/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both streams, predicts the digest words and compares them.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_words,
  output int          digests_seen
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0]  hash_st [8];
  logic [7:0]   blk [64];
  logic [5:0]   fill;
  logic [63:0]  bit_len;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, ch, mj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25)) + ch
         + sha256_pkg::K_TAB[i] + w[i];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic clear_state();
    for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::H_INIT[i];
    fill    = '0;
    bit_len = '0;
  endtask

  task automatic hash_word(input logic cmd, input logic [7:0] b);
    logic [63:0]  total;
    digest_word_t d;
    if (cmd == sha256_pkg::CMD_ABSORB) begin
      blk[fill] = b;
      fill = fill + 6'd1;
      if (fill == 0) begin
        compress_blk();
        bit_len += 64'd512;
      end
    end else begin
      total = bit_len + 64'(fill) * 8;
      blk[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) blk[i] = '0;
      if (fill >= 56) begin
        compress_blk();
        for (int i = 0; i < 56; i++) blk[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_st[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        digest_q.push_back(d);
      end
      clear_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    digests_seen  = 0;
    pending_words = 0;
    clear_state();
  end

  always @(posedge clk) begin
    digest_word_t e;
    if (rst) begin
      clear_state();
    end else begin
      if (s_tvalid && s_tready) hash_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, 32'h0);
        end else begin
          e = digest_q.pop_front();
          if (m_tdata !== e.digest_word) report_mismatch("digest_word", m_tdata, e.digest_word);
          if (m_tuser !== e.word_index) report_mismatch("word_index", 32'(m_tuser), 32'(e.word_index));
          if (m_tlast !== e.last_word) report_mismatch("last_word", 32'(m_tlast), 32'(e.last_word));
          if (e.last_word) digests_seen++;
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest unit testbench
// Directed messages (empty, padding boundaries, byte extremes), then random
// messages of mixed length with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT = 20000;   // cycles with no word moving

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;          // [7:0] data_byte
  logic        s_tuser = 1'b0;        // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;               // [31:0] digest_word
  logic [2:0]  m_tuser;               // [2:0] word_index
  logic        m_tlast;
  int          fail_count, pending_words, digests_seen;
  int          idle_cycles = 0;
  int          bytes_sent = 0;
  int          items_sent = 0;
  int          stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha256_message_digest_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  sha256_digest_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .fail_count, .pending_words, .digests_seen
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, independent of the sender
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= gap_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("tb NOT OK");
      $finish;
    end
  end

  // present one word, hold until accepted, optional gap afterwards
  task automatic send_word(input logic cmd, input logic [7:0] b, input bit gaps);
    int g;
    s_tdata  <= b;
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
    if (cmd == sha256_pkg::CMD_ABSORB) bytes_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_message(input int len, input int pattern, input bit gaps);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: b = 8'h00;
        1: b = 8'hff;
        2: b = 8'(i);
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_word(sha256_pkg::CMD_ABSORB, b, gaps);
    end
    send_word(sha256_pkg::CMD_FINISH, 8'($urandom_range(0, 255)), gaps);
  endtask

  initial begin
    int len;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message and short extremes
    send_message(0, 3, 0);
    send_message(1, 0, 0);
    send_message(2, 1, 0);
    send_message(3, 2, 1);
    send_message(5, 3, 1);

    // sender holds off until every digest word has drained
    s_tvalid <= 1'b0;
    wait (pending_words == 0);
    @(negedge clk);

    // boundary lengths, then random messages (mostly short)
    send_message(55, 3, 1);
    send_message(56, 3, 1);
    send_message(64, 2, 1);
    while (items_sent < 368) begin
      case ($urandom_range(0, 9))
        0: len = 63;
        1: len = $urandom_range(56, 70);
        default: len = $urandom_range(0, 20);
      endcase
      if (len > 367 - items_sent) len = 367 - items_sent;
      send_message(len, 3, 1);
    end
    // back-to-back finishes
    send_word(sha256_pkg::CMD_FINISH, 8'h00, 0);
    send_word(sha256_pkg::CMD_FINISH, 8'hff, 1);
    s_tvalid <= 1'b0;

    wait (pending_words == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d words (%0d message bytes), %0d digests compared",
             items_sent, bytes_sent, digests_seen);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
